// File: rtl/hash_random_direction_sampler_macros.svh
// assertion macros shared by the checker
`ifndef HASH_RANDOM_DIRECTION_SAMPLER_MACROS_SVH
`define HASH_RANDOM_DIRECTION_SAMPLER_MACROS_SVH

// antecedent holds, consequent must hold in the next cycle
`define HRDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sampler check failed");

// antecedent holds, consequent must hold in the same cycle
`define HRDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sampler check failed");

`endif

// File: rtl/hrds_pkg.sv
package hrds_pkg;

    // fixed point format
    localparam int FRAC_BITS = 24;
    localparam int MAX_TRIES = 64;
    localparam int TRY_W     = $clog2(MAX_TRIES);

    // datapath widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int X_W    = FRAC_BITS + 2;
    localparam int S_W    = FRAC_BITS + 2;
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;

    // stream and register port widths
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 128;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // hash constants
    localparam logic [31:0] HASH_MUL_A = 32'd747796405;
    localparam logic [31:0] HASH_ADD   = 32'd2891336453;
    localparam logic [31:0] HASH_MUL_B = 32'd277803737;
    localparam logic [4:0]  HASH_BIAS  = 5'd4;
    localparam int          HASH_FOLD  = 22;

    localparam logic [31:0] RANGE_HIGH_RESET = 32'h0100_0000;

    // operation codes
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_SCALAR = 3'd1;
    localparam logic [2:0] OP_RANGE  = 3'd2;
    localparam logic [2:0] OP_UNIT   = 3'd3;
    localparam logic [2:0] OP_DISK   = 3'd4;
    localparam logic [2:0] OP_HEMI   = 3'd5;

    // register indexes
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HASH_MUL1,
        ST_HASH_MUL2,
        ST_HASH_MIX,
        ST_AFTER_DRAW,
        ST_RNG_ADD,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_SCL_X,
        ST_SCL_Y,
        ST_SCL_END,
        ST_DOT_X,
        ST_DOT_Y,
        ST_DOT_Z,
        ST_DOT_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

// File: rtl/hrds_mul.sv
module hrds_mul (
    input  logic                                clk,
    input  logic signed [hrds_pkg::MUL_W-1:0]   a,
    input  logic signed [hrds_pkg::MUL_W-1:0]   b,
    output logic signed [hrds_pkg::PROD_W-1:0]  prod
);
    import hrds_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // shared signed multiplier, product registered
    always_comb
    begin
        prod_next = a * b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/hrds_isqrt.sv
module hrds_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [hrds_pkg::RAD_W-1:0]        radicand,
    output logic [hrds_pkg::ROOT_W-1:0]       root,
    output hrds_pkg::root_stat_t              stat
);
    import hrds_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [ROOT_W+1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ROOT_W+2:0]  rem_sh;
    logic [ROOT_W+2:0]  trial;

    // one result bit per cycle, two radicand bits brought down each step
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[ROOT_W:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = (ROOT_W+2)'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[ROOT_W+1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/hash_random_direction_sampler.sv
// Hash-driven random direction sampler.
// Input stream (s_*): one transaction per item; op selects load seed, scalar,
// range vec3, unit vector, unit-disk point or hemisphere vector.
// Output stream (m_*): exactly one result transaction per item, held in an
// output register until taken. Range bounds are written over the APB port.
// Each draw passes through the shared multiplier (multiply, mix and multiply,
// fold) and then uses the value. Seed loads and unknown ops go straight to
// the output; scalar takes one draw, range vec3 three. Disk points redraw a
// pair until it lies in the unit disk or the tries run out; unit vectors then
// take the square root and scale the pair; hemisphere adds a dot product.
// One item is worked on at a time: s_tready is high only in the idle state.
// The next item may be accepted while a finished result still waits on m_*.
// If the receiver stalls, a second result waits in the done state until the
// output register frees up.
// Reset clears the seed to zero, range_low to 0.0 and range_high to 1.0, and
// empties the output register.
module hash_random_direction_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    // op[2:0], seed_value[34:3], normal_x[66:35], normal_y[98:67],
    // normal_z[130:99], zero pad[135:131]
    input  logic [hrds_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], seed_now[127:96]
    output logic [hrds_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hrds_pkg::ADDR_W-1:0]       paddr,
    input  logic [hrds_pkg::DATA_W-1:0]       pwdata,
    output logic [hrds_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import hrds_pkg::*;

    localparam logic signed [X_W-1:0] ONE_X = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic [S_W-1:0]        ONE_S = {2'b01, {FRAC_BITS{1'b0}}};

    state_t state_reg, state_next;

    logic [31:0]               seed_reg, seed_next;
    logic [2:0]                op_reg, op_next;
    logic signed [31:0]        nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic signed [31:0]        range_low_reg, range_high_reg;
    logic signed [X_W-1:0]     x_reg, x_next, y_reg, y_next;
    logic [S_W-1:0]            s_reg, s_next;
    logic [ROOT_W:0]           t_reg, t_next;
    logic signed [31:0]        vx_reg, vx_next, vy_reg, vy_next, vz_reg, vz_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [TRY_W-1:0]          tries_reg, tries_next;
    logic [1:0]                idx_reg, idx_next;
    logic                      half_reg, half_next;
    logic [M_DATA_W-1:0]       out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_sum;

    logic                      root_start;
    logic [RAD_W-1:0]          radicand;
    logic [S_W-1:0]            rem;
    logic [ROOT_W-1:0]         root;
    root_stat_t                root_stat;

    logic [FRAC_BITS-1:0]      u;
    logic signed [X_W-1:0]     x_draw;
    logic [31:0]               st;
    logic [4:0]                st_sh;
    logic [31:0]               w0;
    logic [31:0]               w;
    logic signed [MUL_W-1:0]   range_d;
    logic [S_W-1:0]            s_new;
    logic                      s_in;
    logic                      wr_en;

    hrds_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    hrds_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .root     (root),
        .stat     (root_stat)
    );

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_RANGE_HIGH) ? range_high_reg : range_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= RANGE_HIGH_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_RANGE_HIGH)
                range_high_reg <= pwdata;
            else
                range_low_reg <= pwdata;
        end
    end

    // shared datapath terms
    always_comb
    begin
        u        = seed_reg[31 -: FRAC_BITS];
        x_draw   = signed'({1'b0, u, 1'b0}) - ONE_X;
        st       = prod[31:0] + HASH_ADD;
        st_sh    = {1'b0, st[31:28]} + HASH_BIAS;
        w0       = (st >> st_sh) ^ st;
        w        = prod[31:0];
        range_d  = MUL_W'(range_high_reg) - MUL_W'(range_low_reg);
        prod_sh  = prod >>> FRAC_BITS;
        prod_ext = ACC_W'(prod);
        acc_sum  = acc_reg + prod_ext;
        s_new    = acc_sum[FRAC_BITS +: S_W];
        s_in     = (s_new < ONE_S);
        rem      = (s_reg >= ONE_S) ? '0 : (ONE_S - s_reg);
        radicand = {rem, {FRAC_BITS{1'b0}}};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        op_next        = op_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nz_next        = nz_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        acc_next       = acc_reg;
        tries_next     = tries_reg;
        idx_next       = idx_reg;
        half_next      = half_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mul_a          = '0;
        mul_b          = '0;
        root_start     = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next    = s_tdata[2:0];
                    nx_next    = s_tdata[66:35];
                    ny_next    = s_tdata[98:67];
                    nz_next    = s_tdata[130:99];
                    vx_next    = '0;
                    vy_next    = '0;
                    vz_next    = '0;
                    tries_next = '0;
                    idx_next   = '0;
                    half_next  = 1'b0;
                    unique case (s_tdata[2:0])
                        OP_LOAD:
                        begin
                            seed_next  = s_tdata[34:3];
                            state_next = ST_DONE;
                        end
                        OP_SCALAR, OP_RANGE, OP_UNIT, OP_DISK, OP_HEMI:
                            state_next = ST_HASH_MUL1;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            // draw: multiply, add and data-dependent shift, multiply, fold
            ST_HASH_MUL1:
            begin
                mul_a      = MUL_W'(seed_reg);
                mul_b      = MUL_W'(HASH_MUL_A);
                state_next = ST_HASH_MUL2;
            end
            ST_HASH_MUL2:
            begin
                mul_a      = MUL_W'(w0);
                mul_b      = MUL_W'(HASH_MUL_B);
                state_next = ST_HASH_MIX;
            end
            ST_HASH_MIX:
            begin
                seed_next  = (w >> HASH_FOLD) ^ w;
                state_next = ST_AFTER_DRAW;
            end
            ST_AFTER_DRAW:
            begin
                unique case (op_reg)
                    OP_SCALAR:
                    begin
                        vx_next    = 32'(u);
                        state_next = ST_DONE;
                    end
                    OP_RANGE:
                    begin
                        mul_a      = range_d;
                        mul_b      = MUL_W'(u);
                        state_next = ST_RNG_ADD;
                    end
                    default:
                    begin
                        if (!half_reg)
                        begin
                            x_next     = x_draw;
                            half_next  = 1'b1;
                            state_next = ST_HASH_MUL1;
                        end
                        else
                        begin
                            y_next     = x_draw;
                            half_next  = 1'b0;
                            state_next = ST_SQ_X;
                        end
                    end
                endcase
            end
            ST_RNG_ADD:
            begin
                unique case (idx_reg)
                    2'd0:    vx_next = range_low_reg + prod_sh[31:0];
                    2'd1:    vy_next = range_low_reg + prod_sh[31:0];
                    default: vz_next = range_low_reg + prod_sh[31:0];
                endcase
                idx_next   = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd2) ? ST_DONE : ST_HASH_MUL1;
            end
            // radius test of the drawn pair
            ST_SQ_X:
            begin
                mul_a      = MUL_W'(x_reg);
                mul_b      = MUL_W'(x_reg);
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                mul_a      = MUL_W'(y_reg);
                mul_b      = MUL_W'(y_reg);
                acc_next   = prod_ext;
                state_next = ST_SQ_SUM;
            end
            ST_SQ_SUM:
            begin
                s_next = s_new;
                if (s_in || (tries_reg == TRY_W'(MAX_TRIES - 1)))
                begin
                    if (op_reg == OP_DISK)
                    begin
                        vx_next    = 32'(x_reg);
                        vy_next    = 32'(y_reg);
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_ROOT_START;
                end
                else
                begin
                    tries_next = tries_reg + 1'b1;
                    state_next = ST_HASH_MUL1;
                end
            end
            ST_ROOT_START:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (root_stat.done)
                begin
                    t_next     = {root, 1'b0};
                    state_next = ST_SCL_X;
                end
            end
            // scale the pair onto the sphere
            ST_SCL_X:
            begin
                mul_a      = MUL_W'(x_reg);
                mul_b      = MUL_W'(t_reg);
                state_next = ST_SCL_Y;
            end
            ST_SCL_Y:
            begin
                mul_a      = MUL_W'(y_reg);
                mul_b      = MUL_W'(t_reg);
                vx_next    = prod_sh[31:0];
                state_next = ST_SCL_END;
            end
            ST_SCL_END:
            begin
                vy_next    = prod_sh[31:0];
                vz_next    = 32'(ONE_S) - 32'({s_reg, 1'b0});
                state_next = (op_reg == OP_HEMI) ? ST_DOT_X : ST_DONE;
            end
            // dot product with the normal, flip when not in front
            ST_DOT_X:
            begin
                mul_a      = MUL_W'(nx_reg);
                mul_b      = MUL_W'(vx_reg);
                state_next = ST_DOT_Y;
            end
            ST_DOT_Y:
            begin
                mul_a      = MUL_W'(ny_reg);
                mul_b      = MUL_W'(vy_reg);
                acc_next   = prod_ext;
                state_next = ST_DOT_Z;
            end
            ST_DOT_Z:
            begin
                mul_a      = MUL_W'(nz_reg);
                mul_b      = MUL_W'(vz_reg);
                acc_next   = acc_sum;
                state_next = ST_DOT_SUM;
            end
            ST_DOT_SUM:
            begin
                if (acc_sum <= 0)
                begin
                    vx_next = -vx_reg;
                    vy_next = -vy_reg;
                    vz_next = -vz_reg;
                end
                state_next = ST_DONE;
            end
            // hand the result to the output register
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = {seed_reg, vz_reg, vy_reg, vx_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
            tries_reg     <= '0;
            idx_reg       <= '0;
            half_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            tries_reg     <= tries_next;
            idx_reg       <= idx_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        nz_reg  <= nz_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        s_reg   <= s_next;
        t_reg   <= t_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        vz_reg  <= vz_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// File: rtl/hrds_checker.sv
`include "hash_random_direction_sampler_macros.svh"

module hrds_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [hrds_pkg::M_DATA_W-1:0]     m_tdata
);
    import hrds_pkg::*;

    // a stalled result stays offered
    `HRDS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // a stalled result keeps its data
    `HRDS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // the block is busy right after taking an item
    `HRDS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a new result appears only as the sequencer returns to idle
    `HRDS_ASSERT_NOW(a_ready_on_result, $rose(m_tvalid), s_tready)

endmodule

bind hash_random_direction_sampler hrds_checker u_hrds_checker (.*);

// File: test/tb_top.sv
module tb_top;
    import hrds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] seed_value;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
    } sample_req_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] seed_now;
    } sample_res_t;

    typedef struct {
        sample_req_t req;
        bit          fixed;
        sample_res_t res;
    } table_row_t;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam longint ONE_Q = 64'sd1 << FRAC_BITS;

    logic                clk;
    logic                rst_n;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor state
    logic [31:0] seed_q;
    longint      range_lo_q;
    longint      range_hi_q;

    sample_res_t pending_samples[$];
    int          mismatch_count;
    int          burst_left;

    hash_random_direction_sampler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // pcg output hash
    function automatic logic [31:0] pcg_hash(input logic [31:0] v);
        logic [31:0] st;
        logic [31:0] w;
        st = v * HASH_MUL_A + HASH_ADD;
        w = ((st >> ((st >> 28) + 32'd4)) ^ st) * HASH_MUL_B;
        return (w >> HASH_FOLD) ^ w;
    endfunction

    // advance the seed and return the uniform fraction
    function automatic longint next_fraction();
        seed_q = pcg_hash(seed_q);
        return longint'({32'd0, seed_q >> (32 - FRAC_BITS)});
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    // rejection loop for a point in the unit disk, returns s
    function automatic longint disk_point(output longint px, output longint py);
        longint s;
        s = 0;
        px = 0;
        py = 0;
        for (int k = 0; k < MAX_TRIES; k++)
        begin
            px = 2 * next_fraction() - ONE_Q;
            py = 2 * next_fraction() - ONE_Q;
            s = (px * px + py * py) >>> FRAC_BITS;
            if (s < ONE_Q)
                break;
        end
        return s;
    endfunction

    function automatic void sphere_point(output longint vx, output longint vy,
                                         output longint vz);
        longint px;
        longint py;
        longint s;
        longint rem;
        longint t;
        s = disk_point(px, py);
        rem = ONE_Q - s;
        if (rem < 0)
            rem = 0;
        t = 2 * longint'(int_sqrt(longint'(rem) << FRAC_BITS));
        vx = (px * t) >>> FRAC_BITS;
        vy = (py * t) >>> FRAC_BITS;
        vz = ONE_Q - 2 * s;
    endfunction

    function automatic sample_res_t predict_sample(input sample_req_t r);
        longint      v[3];
        longint      span;
        longint      dot;
        sample_res_t res;
        v = '{0, 0, 0};
        case (r.op)
            OP_LOAD:   seed_q = r.seed_value;
            OP_SCALAR: v[0] = next_fraction();
            OP_RANGE:
            begin
                span = range_hi_q - range_lo_q;
                for (int i = 0; i < 3; i++)
                    v[i] = range_lo_q + ((span * next_fraction()) >>> FRAC_BITS);
            end
            OP_UNIT:   sphere_point(v[0], v[1], v[2]);
            OP_DISK:   void'(disk_point(v[0], v[1]));
            OP_HEMI:
            begin
                sphere_point(v[0], v[1], v[2]);
                dot = longint'(signed'(r.nx)) * v[0] + longint'(signed'(r.ny)) * v[1]
                    + longint'(signed'(r.nz)) * v[2];
                if (dot <= 0)
                    for (int i = 0; i < 3; i++)
                        v[i] = -v[i];
            end
            default: ;
        endcase
        res.out_x = v[0][31:0];
        res.out_y = v[1][31:0];
        res.out_z = v[2][31:0];
        res.seed_now = seed_q;
        return res;
    endfunction

    // register write through apb, updates the predictor copy
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RANGE_LOW)
            range_lo_q = longint'(signed'(value));
        else
            range_hi_q = longint'(signed'(value));
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // drive one item, bursts with random gaps
    task automatic send_sample(input sample_req_t r, input bit fixed,
                               input sample_res_t typed);
        sample_res_t res;
        s_tdata  <= {5'd0, r.nz, r.ny, r.nx, r.seed_value, r.op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        res = predict_sample(r);
        pending_samples.push_back(fixed ? typed : res);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
        else
            burst_left--;
    endtask

    function automatic sample_req_t random_req();
        sample_req_t r;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            r.op = OP_LOAD;
        else if (pick < 9)
            r.op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
        else
            r.op = 3'($urandom_range(1, 5));
        r.seed_value = $urandom;
        r.nx = $urandom;
        r.ny = $urandom;
        r.nz = $urandom;
        if ($urandom_range(0, 3) == 0)
        begin
            r.nx = $urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000;
            r.ny = 32'd0;
        end
        return r;
    endfunction

    // receiver stall pattern
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        sample_res_t want;
        sample_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.out_x    = m_tdata[31:0];
            got.out_y    = m_tdata[63:32];
            got.out_z    = m_tdata[95:64];
            got.seed_now = m_tdata[127:96];
            if (pending_samples.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction %h", m_tdata);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h s=%h got x=%h y=%h z=%h s=%h",
                                 want.out_x, want.out_y, want.out_z, want.seed_now,
                                 got.out_x, got.out_y, got.out_z, got.seed_now);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        table_row_t  dir_tab[$];
        table_row_t  row;
        sample_res_t none;
        logic [31:0] lo_set[4];
        logic [31:0] hi_set[4];
        int          guard;

        rst_n    = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mismatch_count = 0;
        burst_left = 0;
        seed_q = 32'd0;
        range_lo_q = 0;
        range_hi_q = ONE_Q;
        none = '{32'd0, 32'd0, 32'd0, 32'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: fixed results for loads and unused ops
        dir_tab.push_back('{'{OP_UNUSED_6, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, none});
        dir_tab.push_back('{'{OP_SCALAR, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        dir_tab.push_back('{'{OP_RANGE, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        dir_tab.push_back('{'{OP_LOAD, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0}, 1'b1,
                            '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}});
        dir_tab.push_back('{'{OP_SCALAR, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                            1'b0, none});
        dir_tab.push_back('{'{OP_UNIT, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        dir_tab.push_back('{'{OP_DISK, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        dir_tab.push_back('{'{OP_HEMI, 32'd0, 32'd0, 32'd0, 32'h0100_0000}, 1'b0, none});
        dir_tab.push_back('{'{OP_HEMI, 32'd0, 32'd0, 32'd0, 32'hFF00_0000}, 1'b0, none});
        // zero normal: dot is zero so the vector flips
        dir_tab.push_back('{'{OP_HEMI, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        dir_tab.push_back('{'{OP_HEMI, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                            1'b0, none});
        dir_tab.push_back('{'{OP_HEMI, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                            1'b0, none});
        dir_tab.push_back('{'{OP_LOAD, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, none});
        dir_tab.push_back('{'{OP_UNIT, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        dir_tab.push_back('{'{OP_UNUSED_7, 32'h1234_5678, 32'd0, 32'd0, 32'd0}, 1'b1, none});
        dir_tab.push_back('{'{OP_LOAD, 32'h8000_0000, 32'd0, 32'd0, 32'd0}, 1'b1,
                            '{32'd0, 32'd0, 32'd0, 32'h8000_0000}});
        dir_tab.push_back('{'{OP_DISK, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        dir_tab.push_back('{'{OP_RANGE, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
        // seed 0 rows follow the earlier load, so their typed seed is stale: patch
        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.fixed)
            begin
                if (row.req.op == OP_LOAD)
                    row.res.seed_now = row.req.seed_value;
                else
                    row.fixed = 1'b0;
            end
            send_sample(row.req, row.fixed, row.res);
        end

        // range settings: reversed, extremes, equal bounds, random
        lo_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0200_0000, $urandom};
        hi_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0200_0000, $urandom};
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
                write_reg(REG_RANGE_LOW, lo_set[phase-1]);
                write_reg(REG_RANGE_HIGH, hi_set[phase-1]);
                if (phase == 1)
                    send_sample('{OP_RANGE, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none);
            end
            for (int n = 0; n < 300; n++)
                send_sample(random_req(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        // drain
        guard = 0;
        while (pending_samples.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
